@@ rtl/core/string_to_integer_parser_unit_assert.svh @@
// Assertion macros shared by the string to integer parser RTL.
// Each expects clk and rst_n in the scope where it is used.
`ifndef STRING_TO_INTEGER_PARSER_UNIT_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/stp_pkg.sv @@
// Package for the string to integer parser: word types, phase codes,
// character constants and the character classification functions.
// No dependencies.
package stp_pkg;

    localparam int RADIX_W     = 6;
    localparam int END_W       = 13;
    localparam int VALUE_W     = 64;
    localparam int DIGIT_W     = 6;
    localparam int MAX_LEN_DEF = 4096;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 6'd63;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXMARK,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [END_W-1:0]          end_index;
        logic                      converted;
    } out_word_t;

    // Input register to parse step.
    typedef struct packed {
        logic     go;
        in_word_t word;
    } step_t;

    // Parse step to output register.
    typedef struct packed {
        logic      load;
        out_word_t word;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
            d = c - CH_ZERO;
        else if ((c >= CH_A_UP) && (c <= CH_Z_UP))
            d = c - CH_A_UP + 8'(DIGIT_TEN);
        else if ((c >= CH_A_LO) && (c <= CH_Z_LO))
            d = c - CH_A_LO + 8'(DIGIT_TEN);
        else
            d = 8'(DIGIT_NONE);
        return d[DIGIT_W-1:0];
    endfunction

endpackage

@@ rtl/core/stp_in_stage.sv @@
// Input register of the string to integer parser.
// Holds one accepted word until the parse step can take it. Uses stp_pkg.
`include "string_to_integer_parser_unit_assert.svh"

module stp_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  stp_pkg::in_word_t in_word,
    input  logic             out_free,
    output stp_pkg::step_t   step
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    stp_pkg::in_word_t s1_word_reg;
    logic             go;
    logic             accept;

    // a non-final word never needs the output register
    assign go       = s1_valid_reg && (!s1_word_reg.is_last || out_free);
    assign in_stall = s1_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_word_reg <= in_word;
    end

    assign step.go   = go;
    assign step.word = s1_word_reg;

    `STP_ASSERT_NOW(a_stall_only_when_held, in_stall, s1_valid_reg && s1_word_reg.is_last,
        "input stalled without a held final word")

endmodule

@@ rtl/core/stp_core.sv @@
// Parse step of the string to integer parser: per-string state and the
// combinational multiply-accumulate. Uses stp_pkg.
`include "string_to_integer_parser_unit_assert.svh"

module stp_core
#(
    parameter int MAX_LEN = stp_pkg::MAX_LEN_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [stp_pkg::RADIX_W-1:0]   radix,
    input  stp_pkg::step_t                step,
    output stp_pkg::res_t                 res
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

    stp_pkg::phase_t              phase_reg, phase_next;
    logic [stp_pkg::VALUE_W-1:0]  acc_reg, acc_next;
    logic                         minus_reg, minus_next;
    logic [stp_pkg::RADIX_W-1:0]  base_reg, base_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [POS_W-1:0]             end_reg, end_next;
    logic                         seen_reg, seen_next;

    logic [7:0]                   c;
    logic [POS_W-1:0]             pos_inc;
    logic [stp_pkg::DIGIT_W-1:0]  d;
    logic [stp_pkg::VALUE_W-1:0]  dext;
    logic [stp_pkg::VALUE_W-1:0]  sd;
    logic [stp_pkg::VALUE_W-1:0]  prod;
    logic                         start;
    logic                         take;
    logic [POS_W+stp_pkg::END_W-1:0] end_ext;

    assign c       = step.word.char_code;
    assign pos_inc = (pos_reg >= POS_MAX) ? POS_MAX : pos_reg + 1'b1;
    assign d       = stp_pkg::digit_of(c);
    assign dext    = {{(stp_pkg::VALUE_W-stp_pkg::DIGIT_W){1'b0}}, d};
    // accumulate the signed value directly: the sign is known before any digit
    assign sd      = minus_reg ? (stp_pkg::VALUE_W'(0) - dext) : dext;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        base_next  = base_reg;
        end_next   = end_reg;
        seen_next  = seen_reg;
        start      = 1'b0;
        take       = 1'b0;
        prod       = '0;

        unique case (phase_reg)
            stp_pkg::PH_WS:
            begin
                if (stp_pkg::is_ws(c))
                    phase_next = stp_pkg::PH_WS;
                else if ((c == stp_pkg::CH_PLUS) || (c == stp_pkg::CH_MINUS))
                begin
                    minus_next = (c == stp_pkg::CH_MINUS);
                    phase_next = stp_pkg::PH_SIGNED;
                end
                else
                    start = 1'b1;
            end
            stp_pkg::PH_SIGNED:
                start = 1'b1;
            stp_pkg::PH_ZERO:
            begin
                if ((c == stp_pkg::CH_X_LO) || (c == stp_pkg::CH_X_UP))
                begin
                    base_next  = stp_pkg::BASE_HEX;
                    phase_next = stp_pkg::PH_HEXMARK;
                end
                else
                    take = 1'b1;
            end
            stp_pkg::PH_HEXMARK,
            stp_pkg::PH_DIGITS:
                take = 1'b1;
            default:
                phase_next = stp_pkg::PH_DONE;
        endcase

        if (start)
        begin
            if ((radix == stp_pkg::BASE_ONE) || (radix > stp_pkg::BASE_MAX))
                phase_next = stp_pkg::PH_DONE;
            else if (((radix == stp_pkg::BASE_AUTO) || (radix == stp_pkg::BASE_HEX)) &&
                     (c == stp_pkg::CH_ZERO))
            begin
                base_next  = (radix == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_OCT
                                                           : stp_pkg::BASE_HEX;
                seen_next  = 1'b1;
                end_next   = pos_inc;
                phase_next = stp_pkg::PH_ZERO;
            end
            else
            begin
                base_next = (radix == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_DEC : radix;
                take      = 1'b1;
            end
        end

        if (take)
        begin
            if ((base_next >= stp_pkg::BASE_MIN) && (base_next <= stp_pkg::BASE_MAX) &&
                (d < base_next))
            begin
                prod       = acc_reg * stp_pkg::VALUE_W'(base_next);
                acc_next   = prod + sd;
                seen_next  = 1'b1;
                end_next   = pos_inc;
                phase_next = stp_pkg::PH_DIGITS;
            end
            else
                phase_next = stp_pkg::PH_DONE;
        end

        pos_next = pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= stp_pkg::PH_WS;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            base_reg  <= '0;
            pos_reg   <= '0;
            end_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step.go)
        begin
            // final word: report, then start the next string clean
            if (step.word.is_last)
            begin
                phase_reg <= stp_pkg::PH_WS;
                acc_reg   <= '0;
                minus_reg <= 1'b0;
                base_reg  <= '0;
                pos_reg   <= '0;
                end_reg   <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                minus_reg <= minus_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                end_reg   <= end_next;
                seen_reg  <= seen_next;
            end
        end
    end

    // result reflects the state after this word, before the clear
    always_comb
    begin
        end_ext            = {{stp_pkg::END_W{1'b0}}, end_next};
        res.load           = step.go && step.word.is_last;
        res.word.converted = seen_next;
        res.word.value     = seen_next ? acc_next : '0;
        res.word.end_index = seen_next ? end_ext[stp_pkg::END_W-1:0] : '0;
    end

    `STP_ASSERT_NOW(a_seen_has_end, seen_reg, end_reg != '0,
        "digit seen without an end position")

endmodule

@@ rtl/core/stp_out_stage.sv @@
// Output register of the string to integer parser.
// Holds one result word until the receiver takes it. Uses stp_pkg.
`include "string_to_integer_parser_unit_assert.svh"

module stp_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  stp_pkg::res_t      res,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_stall,
    output stp_pkg::out_word_t out_word
);

    logic               valid_reg;
    logic               valid_next;
    stp_pkg::out_word_t word_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
            word_reg <= res.word;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    `STP_ASSERT_NOW(a_no_overwrite, res.load, out_free,
        "result loaded over a stalled word")
    `STP_ASSERT_NEXT(a_load_shows, res.load, valid_reg && (word_reg == $past(res.word)),
        "loaded result not presented")

endmodule

@@ rtl/core/string_to_integer_parser_unit.sv @@
// Top level of the string to integer parser: radix register and the
// input register, parse step and output register. Uses stp_pkg and stp_* modules.
//
// Usage:
//   Input channel (in_valid, in_stall, in_word) carries one character word per
//   cycle while in_stall is low; in_word.is_last marks the final character of a
//   string, which is parsed like the others. The output channel (out_valid,
//   out_stall, out_word) carries one result word per string: the value (two's
//   complement, wraps modulo 2^64), end_index and converted.
//   cfg_we/cfg_wdata write the radix (0 auto-detect, 2..36 base); write only
//   while no string is in flight.
//   Throughput: one character word per cycle while in_stall is low; the
//   parse step's multiply-accumulate is combinational.
//   Path: input register, parse step, output register, which drives out_valid.
//   Reset: radix returns to 10, all string state clears, both valids drop.
//   A stalled output holds its word; non-final words keep flowing, and a
//   final word waits in the input register, which then asserts in_stall.
module string_to_integer_parser_unit
#(
    parameter int MAX_LEN = stp_pkg::MAX_LEN_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  stp_pkg::in_word_t           in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output stp_pkg::out_word_t          out_word,
    input  logic                        cfg_we,
    input  logic [stp_pkg::RADIX_W-1:0] cfg_wdata
);

    logic [stp_pkg::RADIX_W-1:0] radix_reg;
    logic [stp_pkg::RADIX_W-1:0] radix_next;
    logic                        out_free;
    stp_pkg::step_t              step;
    stp_pkg::res_t               res;

    assign radix_next = cfg_we ? cfg_wdata : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= stp_pkg::RADIX_RESET;
        else
            radix_reg <= radix_next;
    end

    stp_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_free (out_free),
        .step     (step)
    );

    stp_core #(.MAX_LEN(MAX_LEN)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .radix (radix_reg),
        .step  (step),
        .res   (res)
    );

    stp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

@@ bench/tb_string_to_integer_parser_unit.sv @@
// Testbench for string_to_integer_parser_unit: directed strings, most checked
// against pinned table values, and random strings checked word by word against
// an in-bench parser predictor. Depends on stp_pkg and the parser RTL.
module tb_string_to_integer_parser_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int NOT_DIGIT = 99;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AT = 40;
    localparam logic [stp_pkg::END_W-1:0] POS_CAP = stp_pkg::END_W'(stp_pkg::MAX_LEN_DEF);

    typedef struct {
        logic [stp_pkg::RADIX_W-1:0] rdx;
        string                       txt;
        int                          zero_at;
        bit                          pinned;
        logic [stp_pkg::VALUE_W-1:0] w_val;
        logic [stp_pkg::END_W-1:0]   w_end;
        logic                        w_conv;
    } row_t;

    typedef struct {
        bit                 pinned;
        stp_pkg::out_word_t want;
    } pin_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    stp_pkg::in_word_t           in_word = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    stp_pkg::out_word_t          out_word;
    logic                        cfg_we = 1'b0;
    logic [stp_pkg::RADIX_W-1:0] cfg_wdata = '0;

    // parser predictor state
    stp_pkg::phase_t             ps_phase;
    logic [stp_pkg::VALUE_W-1:0] ps_acc;
    logic                        ps_neg;
    logic [stp_pkg::RADIX_W-1:0] ps_base;
    logic [stp_pkg::END_W-1:0]   ps_pos;
    logic [stp_pkg::END_W-1:0]   ps_end;
    logic                        ps_seen;
    logic [stp_pkg::RADIX_W-1:0] ps_radix = stp_pkg::RADIX_RESET;

    stp_pkg::out_word_t pending_results[$];
    pin_t               pinned_results[$];
    logic [7:0]         line_buf[$];
    row_t               dir_rows[$];
    int                 strings_sent = 0;
    int                 results_checked = 0;
    int                 errors = 0;
    int                 rand_items = 0;
    int                 tx_calm = 0;
    int                 rx_calm = 0;
    int unsigned        cycles = 0;

    string_to_integer_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("string_to_integer_parser_unit: mismatch");
            $finish;
        end
    end

    function automatic void clear_string();
        ps_phase = stp_pkg::PH_WS;
        ps_acc   = '0;
        ps_neg   = 1'b0;
        ps_base  = '0;
        ps_pos   = '0;
        ps_end   = '0;
        ps_seen  = 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return (c == stp_pkg::CH_SPACE) || (c >= stp_pkg::CH_TAB && c <= stp_pkg::CH_CR);
    endfunction

    function automatic int char_digit(input logic [7:0] c);
        if (c >= stp_pkg::CH_ZERO && c <= stp_pkg::CH_NINE)
            return int'(c - stp_pkg::CH_ZERO);
        if (c >= stp_pkg::CH_A_UP && c <= stp_pkg::CH_Z_UP)
            return int'(c - stp_pkg::CH_A_UP) + 10;
        if (c >= stp_pkg::CH_A_LO && c <= stp_pkg::CH_Z_LO)
            return int'(c - stp_pkg::CH_A_LO) + 10;
        return NOT_DIGIT;
    endfunction

    function automatic logic [stp_pkg::END_W-1:0] bump(input logic [stp_pkg::END_W-1:0] p);
        return (p >= POS_CAP) ? POS_CAP : p + 1'b1;
    endfunction

    function automatic void accept_digit(input logic [7:0] c);
        int d;
        d = char_digit(c);
        if (ps_base >= stp_pkg::BASE_MIN && ps_base <= stp_pkg::BASE_MAX && d < int'(ps_base))
        begin
            ps_acc   = ps_acc * stp_pkg::VALUE_W'(ps_base) + stp_pkg::VALUE_W'(d);
            ps_seen  = 1'b1;
            ps_end   = bump(ps_pos);
            ps_phase = stp_pkg::PH_DIGITS;
        end
        else
            ps_phase = stp_pkg::PH_DONE;
    endfunction

    function automatic void begin_number(input logic [7:0] c);
        if (ps_radix == stp_pkg::BASE_ONE || ps_radix > stp_pkg::BASE_MAX)
            ps_phase = stp_pkg::PH_DONE;
        else if ((ps_radix == stp_pkg::BASE_AUTO || ps_radix == stp_pkg::BASE_HEX) &&
                 c == stp_pkg::CH_ZERO)
        begin
            ps_base  = (ps_radix == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_OCT
                                                        : stp_pkg::BASE_HEX;
            ps_seen  = 1'b1;
            ps_end   = bump(ps_pos);
            ps_phase = stp_pkg::PH_ZERO;
        end
        else
        begin
            ps_base = (ps_radix == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_DEC : ps_radix;
            accept_digit(c);
        end
    endfunction

    // Advances the predictor by one word; returns 1 with the result on a final word.
    function automatic bit parse_char(input logic [7:0] c, input logic last,
                                      output stp_pkg::out_word_t res);
        res = '0;
        case (ps_phase)
            stp_pkg::PH_WS:
                if (!is_blank(c))
                begin
                    if (c == stp_pkg::CH_PLUS || c == stp_pkg::CH_MINUS)
                    begin
                        ps_neg   = (c == stp_pkg::CH_MINUS);
                        ps_phase = stp_pkg::PH_SIGNED;
                    end
                    else
                        begin_number(c);
                end
            stp_pkg::PH_SIGNED:
                begin_number(c);
            stp_pkg::PH_ZERO:
                if (c == stp_pkg::CH_X_LO || c == stp_pkg::CH_X_UP)
                begin
                    ps_base  = stp_pkg::BASE_HEX;
                    ps_phase = stp_pkg::PH_HEXMARK;
                end
                else
                    accept_digit(c);
            stp_pkg::PH_HEXMARK, stp_pkg::PH_DIGITS:
                accept_digit(c);
            default:
                ps_phase = stp_pkg::PH_DONE;
        endcase
        ps_pos = bump(ps_pos);
        if (!last)
            return 1'b0;
        if (ps_seen)
        begin
            res.value     = ps_neg ? -ps_acc : ps_acc;
            res.end_index = ps_end;
            res.converted = 1'b1;
        end
        clear_string();
        return 1'b1;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // scoreboard
    always @(posedge clk)
    begin
        stp_pkg::out_word_t got_w;
        stp_pkg::out_word_t want;
        pin_t               pin;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected word value=%0d end_index=%0d converted=%0b",
                             $time, out_word.value, out_word.end_index, out_word.converted);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_word.value !== want.value)
                    begin
                        $display("%0t: value expected %0d got %0d",
                                 $time, want.value, out_word.value);
                        errors++;
                    end
                    if (out_word.end_index !== want.end_index)
                    begin
                        $display("%0t: end_index expected %0d got %0d",
                                 $time, want.end_index, out_word.end_index);
                        errors++;
                    end
                    if (out_word.converted !== want.converted)
                    begin
                        $display("%0t: converted expected %0b got %0b",
                                 $time, want.converted, out_word.converted);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (parse_char(in_word.char_code, in_word.is_last, got_w))
                begin
                    pin = pinned_results.pop_front();
                    pending_results.push_back(pin.pinned ? pin.want : got_w);
                end
            end
        end
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        int n;
        int got;
        got = 0;
        @(posedge rst_n);
        forever
        begin
            n = (got == HOLD_AT) ? LONG_HOLD : draw_wait(rx_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got++;
        end
    end

    task automatic send_line(input bit pin, input stp_pkg::out_word_t want, input bit quick);
        pin_t p;
        int   gap;
        p.pinned = pin;
        p.want   = want;
        pinned_results.push_back(p);
        strings_sent++;
        for (int i = 0; i < line_buf.size(); i++)
        begin
            gap = quick ? 0 : draw_wait(tx_calm);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_word  <= '{char_code: line_buf[i], is_last: (i == line_buf.size() - 1)};
            do @(posedge clk); while (in_stall);
            rand_items++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_checked < strings_sent) @(posedge clk);
    endtask

    task automatic write_radix(input logic [stp_pkg::RADIX_W-1:0] v);
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ps_radix = v;
    endtask

    function automatic logic [stp_pkg::RADIX_W-1:0] pick_radix();
        int k;
        k = $urandom_range(0, 19);
        if (k < 3)
            return stp_pkg::BASE_AUTO;
        if (k == 3)
            return $urandom_range(0, 1) ? stp_pkg::BASE_ONE
                                        : stp_pkg::RADIX_W'($urandom_range(37, 63));
        if (k == 4)
            return stp_pkg::BASE_MAX;
        if (k == 5)
            return stp_pkg::BASE_MIN;
        if (k == 6)
            return stp_pkg::BASE_HEX;
        return stp_pkg::RADIX_W'($urandom_range(2, 36));
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return stp_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? stp_pkg::CH_A_UP : stp_pkg::CH_A_LO) + 8'(d - 10);
    endfunction

    // Mostly well-formed numbers for the current radix, with noise and broken strings.
    function automatic void build_line();
        int  b;
        int  count;
        bit  first_nz;
        line_buf.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            line_buf.push_back($urandom_range(0, 5) == 5 ? stp_pkg::CH_SPACE
                               : stp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
        case ($urandom_range(0, 3))
            0: line_buf.push_back(stp_pkg::CH_PLUS);
            1: line_buf.push_back(stp_pkg::CH_MINUS);
            default: ;
        endcase
        first_nz = 1'b0;
        b = int'(ps_radix);
        if (ps_radix == stp_pkg::BASE_AUTO)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    line_buf.push_back(stp_pkg::CH_ZERO);
                    line_buf.push_back($urandom_range(0, 1) ? stp_pkg::CH_X_LO
                                                            : stp_pkg::CH_X_UP);
                    b = 16;
                end
                1:
                begin
                    line_buf.push_back(stp_pkg::CH_ZERO);
                    b = 8;
                end
                default:
                begin
                    b = 10;
                    first_nz = 1'b1;
                end
            endcase
        end
        else if (ps_radix == stp_pkg::BASE_HEX && $urandom_range(0, 2) == 0)
        begin
            line_buf.push_back(stp_pkg::CH_ZERO);
            line_buf.push_back($urandom_range(0, 1) ? stp_pkg::CH_X_LO : stp_pkg::CH_X_UP);
        end
        else if (ps_radix == stp_pkg::BASE_ONE || ps_radix > stp_pkg::BASE_MAX)
            b = 10;
        count = $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0)
            count = $urandom_range(14, 25);
        if ($urandom_range(0, 11) == 0)
            count = 0;
        for (int i = 0; i < count; i++)
            line_buf.push_back(digit_char((i == 0 && first_nz) ? $urandom_range(1, 9)
                                                              : $urandom_range(0, b - 1)));
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        stp_pkg::out_word_t want;
        string              s;
        int                 nstr;
        clear_string();
        dir_rows = '{
            '{6'd10, "123",                  -1, 1, 64'd123, 13'd3,  1'b1},
            '{6'd10, "   -42",               -1, 1, -64'd42, 13'd6,  1'b1},
            '{6'd10, "\011\012\013\014\015+7", -1, 1, 64'd7, 13'd7,  1'b1},
            '{6'd10, "-",                    -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd10, "abc",                  -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd10, "9223372036854775807",  -1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 13'd19, 1'b1},
            '{6'd10, "-9223372036854775808", -1, 1, 64'h8000_0000_0000_0000, 13'd20, 1'b1},
            '{6'd10, "18446744073709551617", -1, 1, 64'd1,   13'd20, 1'b1},
            '{6'd10, "12a",                  -1, 1, 64'd12,  13'd2,  1'b1},
            '{6'd10, "5#6",                   1, 1, 64'd5,   13'd1,  1'b1},
            '{6'd10, "7\377",                -1, 1, 64'd7,   13'd1,  1'b1},
            '{6'd10, "+-5",                  -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd10, " 31415926535 ",        -1, 0, 64'd0,   13'd0,  1'b0},
            '{6'd0,  "0x1F",                 -1, 1, 64'd31,  13'd4,  1'b1},
            '{6'd0,  "017",                  -1, 1, 64'd15,  13'd3,  1'b1},
            '{6'd0,  "0xg",                  -1, 1, 64'd0,   13'd1,  1'b1},
            '{6'd0,  "  +0",                 -1, 1, 64'd0,   13'd4,  1'b1},
            '{6'd0,  "-0X7fffffffffffffff",  -1, 1, 64'h8000_0000_0000_0001, 13'd19, 1'b1},
            '{6'd0,  "987z",                 -1, 0, 64'd0,   13'd0,  1'b0},
            '{6'd16, "0xFF",                 -1, 1, 64'd255, 13'd4,  1'b1},
            '{6'd16, "-dEaDbEeF",            -1, 0, 64'd0,   13'd0,  1'b0},
            '{6'd2,  "1012",                 -1, 1, 64'd5,   13'd3,  1'b1},
            '{6'd36, "zZ",                   -1, 1, 64'd1295, 13'd2, 1'b1},
            '{6'd36, "-Hello World",         -1, 0, 64'd0,   13'd0,  1'b0},
            '{6'd1,  "123",                  -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd37, "1",                    -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd63, "5",                    -1, 1, 64'd0,   13'd0,  1'b0},
            '{6'd8,  "  -0778",              -1, 0, 64'd0,   13'd0,  1'b0}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].rdx != ps_radix)
                write_radix(dir_rows[i].rdx);
            s = dir_rows[i].txt;
            line_buf.delete();
            for (int k = 0; k < s.len(); k++)
                line_buf.push_back((k == dir_rows[i].zero_at) ? 8'h00 : s[k]);
            want.value     = dir_rows[i].w_val;
            want.end_index = dir_rows[i].w_end;
            want.converted = dir_rows[i].w_conv;
            send_line(dir_rows[i].pinned, want, 1'b0);
        end

        nstr = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (nstr % 12 == 11)
                write_radix(pick_radix());
            build_line();
            send_line(1'b0, '0, 1'b0);
            nstr++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("string_to_integer_parser_unit: match");
        else
            $display("string_to_integer_parser_unit: mismatch");
        $finish;
    end

endmodule
